/* hdl/pdeb_pkg.sv */
// Shared types, constants and register map of the device-enumeration bus.
`default_nettype none

package pdeb_pkg;

    // Depth of the announcement queue and the widths that follow from it.
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Register window offsets.
    localparam logic [11:0] OFF_OP        = 12'h000;
    localparam logic [11:0] OFF_GET_NAME  = 12'h004;
    localparam logic [11:0] OFF_NAME_LEN  = 12'h008;
    localparam logic [11:0] OFF_ID        = 12'h00c;
    localparam logic [11:0] OFF_BASE      = 12'h010;
    localparam logic [11:0] OFF_SIZE      = 12'h014;
    localparam logic [11:0] OFF_IRQ       = 12'h018;
    localparam logic [11:0] OFF_IRQ_COUNT = 12'h01c;

    // Values returned by a read of the op register.
    localparam logic [31:0] OP_DONE   = 32'h0000_0000;
    localparam logic [31:0] OP_REMOVE = 32'h0000_0004;
    localparam logic [31:0] OP_ADD    = 32'h0000_0008;

    // Kind of request presented on the command port.
    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_WRITE  = 2'd3
    } t_action;

    // Control sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } t_state;

    // One queued announcement as held in the entry memory.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] base;
        logic [31:0] size;
        logic [31:0] irq;
        logic        remove;
        logic [7:0]  name_bytes;
        logic [7:0]  irq_lines;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

/* hdl/platform_device_enumeration_bus.sv */
// Top level of the device-enumeration bus: queue control, current entry and register reads.
//
//  Channel   | Handshake              | Payload
//  ----------+------------------------+---------------------------------------------------
//  command   | start in, busy out     | i_action, i_reg_offset, i_write_data, i_dev_*,
//            |                        | i_name_length
//  result    | o_valid out (1 cycle)  | o_read_data, o_irq_level, o_name_request,
//            |                        | o_name_address, o_bad_offset, o_queue_overflow
//
// Every request except an op read of a non-empty queue takes one cycle: its result strobes
// on the cycle after acceptance and a new request may be taken in that same cycle.
// A popping op read enters ST_POP, with busy high, while the registered entry-memory read
// becomes the current entry and result. Reset is synchronous and leaves the queue
// empty with no current entry; the memory needs no clearing. The receiver cannot stall.
`default_nettype none

module platform_device_enumeration_bus (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            i_action,
    input  wire logic [11:0]           i_reg_offset,
    input  wire logic [31:0]           i_write_data,
    input  wire logic [31:0]           i_dev_id,
    input  wire logic [31:0]           i_dev_base,
    input  wire logic [31:0]           i_dev_size,
    input  wire logic [31:0]           i_dev_irq,
    input  wire logic [7:0]            i_dev_irq_count,
    input  wire logic [7:0]            i_name_length,
    output logic                       o_valid,
    output logic [31:0]                o_read_data,
    output logic                       o_irq_level,
    output logic                       o_name_request,
    output logic [31:0]                o_name_address,
    output logic                       o_bad_offset,
    output logic                       o_queue_overflow
);
    import pdeb_pkg::*;

    // Queue pointers, fill count and sequencer state.
    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;

    // Current entry.
    logic               r_cur_valid, n_cur_valid;
    t_entry             r_cur;

    // Result registers.
    logic               r_valid, n_valid;
    logic [31:0]        r_read_data, n_read_data;
    logic               r_irq_level, n_irq_level;
    logic               r_name_request, n_name_request;
    logic [31:0]        r_name_address, n_name_address;
    logic               r_bad_offset, n_bad_offset;
    logic               r_queue_overflow, n_queue_overflow;

    // Decode of the request.
    t_action            w_action;
    logic               w_accept;
    logic               w_full;
    logic               w_push;
    logic               w_pop;
    logic               w_load_cur;
    t_entry             w_wr_entry;
    t_entry             w_rd_entry;
    logic [31:0]        w_field;

    assign w_action = t_action'(i_action);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_push   = w_accept && !w_full
                      && (w_action == ACT_ADD || w_action == ACT_REMOVE);
    assign w_pop    = w_accept && (w_action == ACT_READ) && (i_reg_offset == OFF_OP)
                      && (r_count != '0);

    // Entry to be queued; a removal keeps only the base.
    always_comb begin
        w_wr_entry        = '0;
        w_wr_entry.base   = i_dev_base;
        if (w_action == ACT_REMOVE) begin
            w_wr_entry.remove = 1'b1;
        end else begin
            w_wr_entry.id         = i_dev_id;
            w_wr_entry.size       = i_dev_size;
            w_wr_entry.irq        = i_dev_irq;
            w_wr_entry.name_bytes = i_name_length;
            w_wr_entry.irq_lines  = i_dev_irq_count;
        end
    end

    // Entry memory: pushes write at the tail, pops read at the head. A pop holds off new
    // requests until its data has been taken, so a read never overlaps a write.
    pdeb_entry_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_push),
        .i_wr_addr (r_tail),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_pop),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd_entry)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        busy       = 1'b0;
        w_load_cur = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                w_load_cur = 1'b0;
            end
            ST_POP: begin
                busy       = 1'b1;
                w_load_cur = 1'b1;
            end
            default: begin
                busy       = 1'b0;
                w_load_cur = 1'b0;
            end
        endcase
    end

    // Pointer and count updates.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_push) begin
            n_tail  = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end else if (w_pop) begin
            n_head  = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    // Field of the current entry selected by the offset; zero with no current entry.
    always_comb begin
        w_field = '0;
        if (i_reg_offset == OFF_NAME_LEN) begin
            w_field = {24'd0, r_cur.name_bytes};
        end else if (i_reg_offset == OFF_ID) begin
            w_field = r_cur.id;
        end else if (i_reg_offset == OFF_BASE) begin
            w_field = r_cur.base;
        end else if (i_reg_offset == OFF_SIZE) begin
            w_field = r_cur.size;
        end else if (i_reg_offset == OFF_IRQ) begin
            w_field = r_cur.irq;
        end else if (i_reg_offset == OFF_IRQ_COUNT) begin
            w_field = {24'd0, r_cur.irq_lines};
        end
        if (!r_cur_valid) begin
            w_field = '0;
        end
    end

    // Result of the request and the current-entry flag.
    always_comb begin
        n_valid          = 1'b0;
        n_read_data      = '0;
        n_name_request   = 1'b0;
        n_name_address   = '0;
        n_bad_offset     = 1'b0;
        n_queue_overflow = 1'b0;
        n_cur_valid      = r_cur_valid;
        if (w_load_cur) begin
            n_valid     = 1'b1;
            n_read_data = w_rd_entry.remove ? OP_REMOVE : OP_ADD;
        end else if (w_accept) begin
            n_valid = !w_pop;
            unique case (w_action)
                ACT_ADD, ACT_REMOVE: begin
                    n_queue_overflow = w_full;
                end
                ACT_READ: begin
                    if (i_reg_offset == OFF_OP) begin
                        n_cur_valid = w_pop;
                        n_read_data = OP_DONE;
                    end else if (i_reg_offset == OFF_NAME_LEN || i_reg_offset == OFF_ID
                                 || i_reg_offset == OFF_BASE || i_reg_offset == OFF_SIZE
                                 || i_reg_offset == OFF_IRQ
                                 || i_reg_offset == OFF_IRQ_COUNT) begin
                        n_read_data = w_field;
                    end else begin
                        n_bad_offset = 1'b1;
                    end
                end
                ACT_WRITE: begin
                    if (i_reg_offset == OFF_GET_NAME) begin
                        n_name_request = r_cur_valid;
                        n_name_address = r_cur_valid ? i_write_data : '0;
                    end else if (i_reg_offset != OFF_OP) begin
                        n_bad_offset = 1'b1;
                    end
                end
                default: begin
                    n_bad_offset = 1'b0;
                end
            endcase
        end
        n_irq_level = n_cur_valid || (n_count != '0);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cur_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_cur_valid <= n_cur_valid;
            r_valid     <= n_valid;
        end
    end

    // Current entry payload, loaded when the popped entry arrives from memory.
    always_ff @(posedge i_clk) begin
        if (w_load_cur) begin
            r_cur <= w_rd_entry;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_read_data      <= n_read_data;
            r_irq_level      <= n_irq_level;
            r_name_request   <= n_name_request;
            r_name_address   <= n_name_address;
            r_bad_offset     <= n_bad_offset;
            r_queue_overflow <= n_queue_overflow;
        end
    end

    assign o_valid          = r_valid;
    assign o_read_data      = r_read_data;
    assign o_irq_level      = r_irq_level;
    assign o_name_request   = r_name_request;
    assign o_name_address   = r_name_address;
    assign o_bad_offset     = r_bad_offset;
    assign o_queue_overflow = r_queue_overflow;

`ifndef SYNTHESIS
    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // An empty queue has its head and tail together.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    // Every accepted request gives a result next cycle unless it started a pop.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || r_state == ST_POP))
        else $error("accepted request produced no result");

    // A completed pop reports an entry and leaves the interrupt raised.
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |=> (o_valid && o_irq_level
                                  && (o_read_data == OP_ADD || o_read_data == OP_REMOVE)))
        else $error("pop finished without a proper result");
`endif

endmodule

`default_nettype wire

/* hdl/pdeb_entry_ram.sv */
// Single-port-write, registered-read memory holding the queued announcements.
`default_nettype none

module pdeb_entry_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* tb/tb_platform_device_enumeration_bus.sv */
// Self-checking testbench for the device-enumeration bus: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_platform_device_enumeration_bus;
    import pdeb_pkg::*;

    // Cycles with neither an accepted request nor a result before the run is abandoned.
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int TAIL_CYCLES   = 6;

    // Readable field registers, used to pick field reads at random.
    localparam logic [11:0] FIELD_OFFSETS [6] = '{OFF_NAME_LEN, OFF_ID, OFF_BASE,
                                                   OFF_SIZE, OFF_IRQ, OFF_IRQ_COUNT};

    // One request on the command port.
    typedef struct {
        t_action     action;
        logic [11:0] offset;
        logic [31:0] wdata;
        logic [31:0] id;
        logic [31:0] base;
        logic [31:0] size;
        logic [31:0] irq;
        logic [7:0]  irq_lines;
        logic [7:0]  name_bytes;
    } t_bus_req;

    // One response strobed on the result port.
    typedef struct {
        logic [31:0] read_data;
        logic        irq_level;
        logic        name_request;
        logic [31:0] name_address;
        logic        bad_offset;
        logic        queue_overflow;
    } t_bus_resp;

    // A row of the directed table; pinned rows carry a response typed in by hand.
    typedef struct {
        t_bus_req  req;
        bit        pinned;
        t_bus_resp resp;
    } t_table_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_action = ACT_READ;
    logic [11:0] i_reg_offset = '0;
    logic [31:0] i_write_data = '0;
    logic [31:0] i_dev_id = '0;
    logic [31:0] i_dev_base = '0;
    logic [31:0] i_dev_size = '0;
    logic [31:0] i_dev_irq = '0;
    logic [7:0]  i_dev_irq_count = '0;
    logic [7:0]  i_name_length = '0;
    logic        o_valid;
    logic [31:0] o_read_data;
    logic        o_irq_level;
    logic        o_name_request;
    logic [31:0] o_name_address;
    logic        o_bad_offset;
    logic        o_queue_overflow;

    // Pinned response travels alongside the request it belongs to.
    bit          pin_on = 1'b0;
    t_bus_resp   pin_resp = '{default: '0};

    // Mirror of the block's queue and current entry.
    t_entry      entry_store [QUEUE_DEPTH];
    int          q_head = 0;
    int          q_tail = 0;
    int          q_count = 0;
    bit          cur_valid = 1'b0;
    t_entry      cur_entry = '0;

    t_bus_resp   pending_resp [$];
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          n_popped = 0;
    int          n_dropped = 0;
    int          n_name_reqs = 0;
    int          idle_cycles = 0;
    int          burst_left = 1;

    platform_device_enumeration_bus dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_reg_offset     (i_reg_offset),
        .i_write_data     (i_write_data),
        .i_dev_id         (i_dev_id),
        .i_dev_base       (i_dev_base),
        .i_dev_size       (i_dev_size),
        .i_dev_irq        (i_dev_irq),
        .i_dev_irq_count  (i_dev_irq_count),
        .i_name_length    (i_name_length),
        .o_valid          (o_valid),
        .o_read_data      (o_read_data),
        .o_irq_level      (o_irq_level),
        .o_name_request   (o_name_request),
        .o_name_address   (o_name_address),
        .o_bad_offset     (o_bad_offset),
        .o_queue_overflow (o_queue_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Queues an announcement, dropping it when the queue is full.
    function automatic bit enqueue_entry(t_entry e);
        if (q_count >= QUEUE_DEPTH) begin
            n_dropped++;
            return 1'b1;
        end
        entry_store[q_tail] = e;
        q_tail = (q_tail + 1) % QUEUE_DEPTH;
        q_count++;
        return 1'b0;
    endfunction

    // Works out the response to one accepted request and advances the mirror.
    function automatic t_bus_resp predict_response(t_bus_req r);
        t_bus_resp resp;
        t_entry    e;
        resp = '{default: '0};
        e = '0;
        case (r.action)
            ACT_ADD: begin
                e.id = r.id;
                e.base = r.base;
                e.size = r.size;
                e.irq = r.irq;
                e.name_bytes = r.name_bytes;
                e.irq_lines = r.irq_lines;
                resp.queue_overflow = enqueue_entry(e);
            end
            ACT_REMOVE: begin
                // A removal keeps only the base and the remove flag; everything else is zero.
                e.base = r.base;
                e.remove = 1'b1;
                resp.queue_overflow = enqueue_entry(e);
            end
            ACT_READ: begin
                case (r.offset)
                    OFF_OP: begin
                        // The op read always drops the current entry first.
                        cur_valid = 1'b0;
                        cur_entry = '0;
                        resp.read_data = OP_DONE;
                        if (q_count != 0) begin
                            cur_entry = entry_store[q_head];
                            cur_valid = 1'b1;
                            q_head = (q_head + 1) % QUEUE_DEPTH;
                            q_count--;
                            n_popped++;
                            resp.read_data = cur_entry.remove ? OP_REMOVE : OP_ADD;
                        end
                    end
                    OFF_NAME_LEN:  resp.read_data = cur_valid ? 32'(cur_entry.name_bytes) : '0;
                    OFF_ID:        resp.read_data = cur_valid ? cur_entry.id : '0;
                    OFF_BASE:      resp.read_data = cur_valid ? cur_entry.base : '0;
                    OFF_SIZE:      resp.read_data = cur_valid ? cur_entry.size : '0;
                    OFF_IRQ:       resp.read_data = cur_valid ? cur_entry.irq : '0;
                    OFF_IRQ_COUNT: resp.read_data = cur_valid ? 32'(cur_entry.irq_lines) : '0;
                    default:       resp.bad_offset = 1'b1;
                endcase
            end
            default: begin
                // Writes: GET_NAME needs a current entry, op write is harmless.
                if (r.offset == OFF_GET_NAME) begin
                    if (cur_valid) begin
                        resp.name_request = 1'b1;
                        resp.name_address = r.wdata;
                        n_name_reqs++;
                    end
                end else if (r.offset != OFF_OP) begin
                    resp.bad_offset = 1'b1;
                end
            end
        endcase
        resp.irq_level = cur_valid || (q_count != 0);
        return resp;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got 0x%08h, expected 0x%08h (result %0d, t=%0t)",
                 what, got, want, n_results, $realtime);
        n_errors++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Result checking, request capture and the watchdog, all on the rising edge.
    always @(posedge i_clk) begin : monitor
        t_bus_req  acc;
        t_bus_resp want;
        t_bus_resp pred;
        bit        took;
        took = i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (pending_resp.size() == 0) begin
                report_mismatch("unexpected result, read_data", o_read_data, '0);
            end else begin
                want = pending_resp.pop_front();
                check_field("read_data", o_read_data, want.read_data);
                check_field("irq_level", 32'(o_irq_level), 32'(want.irq_level));
                check_field("name_request", 32'(o_name_request), 32'(want.name_request));
                check_field("name_address", o_name_address, want.name_address);
                check_field("bad_offset", 32'(o_bad_offset), 32'(want.bad_offset));
                check_field("queue_overflow", 32'(o_queue_overflow),
                            32'(want.queue_overflow));
            end
        end
        if (took) begin
            acc.action = t_action'(i_action);
            acc.offset = i_reg_offset;
            acc.wdata = i_write_data;
            acc.id = i_dev_id;
            acc.base = i_dev_base;
            acc.size = i_dev_size;
            acc.irq = i_dev_irq;
            acc.irq_lines = i_dev_irq_count;
            acc.name_bytes = i_name_length;
            pred = predict_response(acc);
            want = pin_on ? pin_resp : pred;
            pending_resp.push_back(want);
            n_accepted++;
        end
        // Watchdog: only a lack of progress ends the run early.
        if (took || (i_rst_n && o_valid))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("platform_device_enumeration_bus test failed");
            $finish;
        end
    end

    function automatic t_bus_req make_req(t_action a, logic [11:0] off, logic [31:0] wd,
                                          logic [31:0] id, logic [31:0] base,
                                          logic [31:0] size, logic [31:0] irq,
                                          logic [7:0] irqc, logic [7:0] nlen);
        t_bus_req r;
        r = '{action: a, offset: off, wdata: wd, id: id, base: base, size: size,
              irq: irq, irq_lines: irqc, name_bytes: nlen};
        return r;
    endfunction

    function automatic t_bus_resp make_resp(logic [31:0] rd, logic irq, logic nreq,
                                            logic [31:0] naddr, logic bad, logic ovf);
        t_bus_resp r;
        r = '{read_data: rd, irq_level: irq, name_request: nreq, name_address: naddr,
              bad_offset: bad, queue_overflow: ovf};
        return r;
    endfunction

    // Random payload on every field, with the action and offset given.
    function automatic t_bus_req rand_request(t_action a, logic [11:0] off);
        return make_req(a, off, $urandom, $urandom, $urandom, $urandom, $urandom,
                        8'($urandom), 8'($urandom));
    endfunction

    function automatic t_bus_req rand_announcement();
        t_action a;
        a = ($urandom_range(0, 3) == 0) ? ACT_REMOVE : ACT_ADD;
        return rand_request(a, 12'($urandom));
    endfunction

    function automatic t_bus_req rand_field_read();
        return rand_request(ACT_READ, FIELD_OFFSETS[$urandom_range(0, 5)]);
    endfunction

    // Any action at any offset: mapped, unaligned near the map, or anywhere.
    function automatic t_bus_req rand_noise();
        logic [11:0] off;
        case ($urandom_range(0, 2))
            0:       off = 12'($urandom_range(0, 4095));
            1:       off = 12'(4 * $urandom_range(0, 7));
            default: off = 12'($urandom_range(0, 31));
        endcase
        return rand_request(t_action'($urandom_range(0, 3)), off);
    endfunction

    // Holds start low for a number of cycles; nothing is touched for zero.
    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stops sending until every outstanding response has arrived.
    task automatic drain_pause();
        pause_sender(1);
        while (pending_resp.size() != 0)
            @(posedge i_clk);
    endtask

    // Presents one request, waits for it to be taken, then applies the burst pattern.
    task automatic send_request(t_bus_req r, bit pinned, t_bus_resp resp);
        start <= 1'b1;
        i_action <= r.action;
        i_reg_offset <= r.offset;
        i_write_data <= r.wdata;
        i_dev_id <= r.id;
        i_dev_base <= r.base;
        i_dev_size <= r.size;
        i_dev_irq <= r.irq;
        i_dev_irq_count <= r.irq_lines;
        i_name_length <= r.name_bytes;
        pin_on <= pinned;
        pin_resp <= resp;
        do @(posedge i_clk); while (busy);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic send_checked(t_bus_req r);
        send_request(r, 1'b0, '{default: '0});
    endtask

    initial begin : stimulus
        t_table_row  dir_table [$];
        t_bus_resp   none;
        logic [31:0] ones;
        int          n;
        int          k;
        none = '{default: '0};
        ones = '1;

        // Directed table: reset state, illegal offsets, extremes and a full enumeration.
        dir_table.push_back('{make_req(ACT_READ, OFF_OP, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              make_resp(OP_DONE, 0, 0, 0, 0, 0)});
        dir_table.push_back('{make_req(ACT_READ, OFF_ID, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
        dir_table.push_back('{make_req(ACT_WRITE, OFF_GET_NAME, ones, 0, 0, 0, 0, 0, 0),
                              1'b1, none});
        dir_table.push_back('{make_req(ACT_WRITE, OFF_OP, ones, 0, 0, 0, 0, 0, 0),
                              1'b1, none});
        dir_table.push_back('{make_req(ACT_READ, OFF_GET_NAME, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              make_resp(0, 0, 0, 0, 1, 0)});
        dir_table.push_back('{make_req(ACT_READ, 12'hfff, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              make_resp(0, 0, 0, 0, 1, 0)});
        dir_table.push_back('{make_req(ACT_WRITE, 12'h002, ones, 0, 0, 0, 0, 0, 0), 1'b1,
                              make_resp(0, 0, 0, 0, 1, 0)});
        dir_table.push_back('{make_req(ACT_ADD, 12'hfff, ones, ones, ones, ones, ones,
                                       8'hff, 8'hff), 1'b1, make_resp(0, 1, 0, 0, 0, 0)});
        dir_table.push_back('{make_req(ACT_REMOVE, 12'hfff, ones, ones, 0, ones, ones,
                                       8'hff, 8'hff), 1'b0, none});
        dir_table.push_back('{make_req(ACT_ADD, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
        dir_table.push_back('{make_req(ACT_READ, OFF_OP, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              make_resp(OP_ADD, 1, 0, 0, 0, 0)});
        foreach (FIELD_OFFSETS[i])
            dir_table.push_back('{make_req(ACT_READ, FIELD_OFFSETS[i], 0, 0, 0, 0, 0, 0, 0),
                                  1'b0, none});
        dir_table.push_back('{make_req(ACT_WRITE, OFF_GET_NAME, 32'hdead_beef, 0, 0, 0, 0,
                                       0, 0), 1'b0, none});
        dir_table.push_back('{make_req(ACT_READ, OFF_OP, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
        dir_table.push_back('{make_req(ACT_READ, OFF_ID, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
        dir_table.push_back('{make_req(ACT_READ, OFF_NAME_LEN, 0, 0, 0, 0, 0, 0, 0),
                              1'b0, none});
        dir_table.push_back('{make_req(ACT_READ, OFF_OP, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
        dir_table.push_back('{make_req(ACT_READ, OFF_OP, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              make_resp(OP_DONE, 0, 0, 0, 0, 0)});
        dir_table.push_back('{make_req(ACT_READ, OFF_SIZE, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
        dir_table.push_back('{make_req(ACT_WRITE, OFF_GET_NAME, 32'h1234_5678, 0, 0, 0, 0,
                                       0, 0), 1'b1, none});

        // Reset, applied at the start and never repeated.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 20);

        foreach (dir_table[i])
            send_request(dir_table[i].req, dir_table[i].pinned, dir_table[i].resp);
        drain_pause();

        // Random part: mostly whole enumerations, some queue floods, some noise.
        while (n_sent < dir_table.size() + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    n = $urandom_range(1, 5);
                    repeat (n) send_checked(rand_announcement());
                    repeat (n + 1) begin
                        send_checked(rand_request(ACT_READ, OFF_OP));
                        k = $urandom_range(0, 4);
                        repeat (k) send_checked(rand_field_read());
                        if ($urandom_range(0, 2) == 0)
                            send_checked(rand_request(ACT_WRITE, OFF_GET_NAME));
                    end
                end
                6: begin
                    // Flood the queue past its depth, then empty it again.
                    repeat (QUEUE_DEPTH + $urandom_range(1, 3))
                        send_checked(rand_announcement());
                    repeat (QUEUE_DEPTH + 2) begin
                        send_checked(rand_request(ACT_READ, OFF_OP));
                        if ($urandom_range(0, 3) == 0)
                            send_checked(rand_field_read());
                    end
                end
                7, 8: begin
                    repeat ($urandom_range(1, 8)) send_checked(rand_noise());
                end
                default: begin
                    drain_pause();
                    repeat ($urandom_range(1, 4)) send_checked(rand_noise());
                end
            endcase
        end

        // Let every outstanding response arrive, then watch for stray strobes.
        drain_pause();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d responses: %0d entries popped,",
                 n_accepted, n_results, n_popped);
        $display("%0d announcements dropped on a full queue, %0d name-copy requests.",
                 n_dropped, n_name_reqs);
        if (n_errors == 0 && pending_resp.size() == 0)
            $display("platform_device_enumeration_bus test passed");
        else
            $display("platform_device_enumeration_bus test failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/pdeb_pkg.sv
hdl/pdeb_entry_ram.sv
hdl/platform_device_enumeration_bus.sv
tb/tb_platform_device_enumeration_bus.sv
